[hdl/bqsc_pkg.sv]
// ----------------------------------------------------------------------------
// bqsc_pkg
// Shared types, codes and constant tables for the balanced base-5 converter.
// ----------------------------------------------------------------------------
package bqsc_pkg;

  localparam int MaxDigits = 28;
  localparam int IdxW      = $clog2(MaxDigits);
  localparam int ValW      = 64;
  localparam int RemW      = ValW + 1;
  localparam int CharW     = 8;

  localparam logic CmdDigit  = 1'b0;
  localparam logic CmdFlush  = 1'b1;
  localparam logic KindValue = 1'b0;
  localparam logic KindChar  = 1'b1;

  localparam logic [2:0] CodeZero = 3'd2;

  typedef logic [MaxDigits-1:0][RemW-1:0] pow_tab_t;

  function automatic pow_tab_t pow5_table();
    pow_tab_t       t;
    logic [RemW-1:0] p;
    p = RemW'(1);
    for (int i = 0; i < MaxDigits; i++) begin
      t[i] = p;
      p    = p * RemW'(5);
    end
    return t;
  endfunction

  localparam pow_tab_t Pow5 = pow5_table();

  // sum of 2 * 5^i: maps a balanced value onto plain base-5 digits
  function automatic logic [RemW-1:0] bal_offset();
    logic [RemW-1:0] s;
    s = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      s = s + (Pow5[i] << 1);
    end
    return s;
  endfunction

  localparam logic [RemW-1:0] BalOffset = bal_offset();

  function automatic logic [2:0] char_weight(input logic [CharW-1:0] c);
    logic [2:0] w;
    unique case (c)
      8'h32:   w = 3'sd2;
      8'h31:   w = 3'sd1;
      8'h2d:   w = 3'b111;
      8'h3d:   w = 3'b110;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  function automatic logic [CharW-1:0] code_char(input logic [2:0] code);
    logic [CharW-1:0] c;
    unique case (code)
      3'd0:    c = 8'h3d;
      3'd1:    c = 8'h2d;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h31;
      3'd4:    c = 8'h32;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

[hdl/balanced_quinary_sum_converter.sv]
// ----------------------------------------------------------------------------
// balanced_quinary_sum_converter
// Decodes balanced base-5 numbers digit by digit, outputs each value, keeps
// their running sum and writes it out as balanced base-5 characters on a flush.
//
//   channel  dir  tdata                                   tuser     tlast
//   s_axis   in   [7:0] digit_char                        command   last_digit
//   m_axis   out  [63:0] number_value, [71:64] out_char   kind      last
//
// A flush loads the offset sum, then for each output digit position subtracts
// the position's power of 5 once per unit of its plain base-5 digit of the
// offset sum before emitting, all in the single 65-bit compare/subtract unit.
// Reset clears the accumulator, the sum and all control state.
// Input is held off during a flush and while the output holds an untaken beat.
// ----------------------------------------------------------------------------
module balanced_quinary_sum_converter
  import bqsc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CharW-1:0]     s_axis_tdata,   // [7:0] digit_char
  input  logic                 s_axis_tuser,   // command
  input  logic                 s_axis_tlast,   // last_digit
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [ValW+CharW-1:0] m_axis_tdata,  // [63:0] number_value, [71:64] out_char
  output logic                 m_axis_tuser,   // kind
  output logic                 m_axis_tlast    // last
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StConv = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [ValW-1:0]   acc_q, acc_d;
  logic [ValW-1:0]   sum_q, sum_d;
  logic [ValW-1:0]   add_q, add_d;
  logic              pend_q, pend_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [2:0]        dig_q, dig_d;
  logic              started_q, started_d;

  logic              ovalid_q, ovalid_d;
  logic              okind_q, okind_d;
  logic [ValW-1:0]   oval_q, oval_d;
  logic [CharW-1:0]  ochar_q, ochar_d;
  logic              olast_q, olast_d;

  logic              out_free;
  logic              s_fire;
  logic [2:0]        weight;
  logic [ValW-1:0]   acc_next;
  logic [RemW-1:0]   pow_cur;
  logic              ge;
  logic              emit;

  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign weight   = char_weight(s_axis_tdata);
  assign acc_next = {acc_q[ValW-3:0], 2'b00} + acc_q + {{(ValW-3){weight[2]}}, weight};
  assign pow_cur  = Pow5[idx_q];
  assign ge       = rem_q >= pow_cur;
  assign emit     = started_q || (dig_q != CodeZero) || (idx_q == '0);

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    add_d     = add_q;
    pend_d    = 1'b0;
    rem_d     = rem_q;
    idx_d     = idx_q;
    dig_d     = dig_q;
    started_d = started_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    okind_d   = okind_q;
    oval_d    = oval_q;
    ochar_d   = ochar_q;
    olast_d   = olast_q;

    // fold the last finished number into the sum in the cycle after it finishes
    if (pend_q) begin
      sum_d = sum_q + add_q;
    end

    unique case (state_q)
      StIdle: begin
        if (s_fire) begin
          if (s_axis_tuser == CmdFlush) begin
            state_d = StLoad;
          end else if (s_axis_tlast) begin
            acc_d    = '0;
            add_d    = acc_next;
            pend_d   = 1'b1;
            ovalid_d = 1'b1;
            okind_d  = KindValue;
            oval_d   = acc_next;
            ochar_d  = '0;
            olast_d  = 1'b1;
          end else begin
            acc_d = acc_next;
          end
        end
      end
      StLoad: begin
        rem_d     = {sum_q[ValW-1], sum_q} + BalOffset;
        sum_d     = '0;
        idx_d     = IdxW'(MaxDigits - 1);
        dig_d     = '0;
        started_d = 1'b0;
        state_d   = StConv;
      end
      StConv: begin
        if (ge) begin
          rem_d = rem_q - pow_cur;
          dig_d = dig_q + 3'd1;
        end else if (!emit || out_free) begin
          if (emit) begin
            ovalid_d  = 1'b1;
            okind_d   = KindChar;
            oval_d    = '0;
            ochar_d   = code_char(dig_q);
            olast_d   = (idx_q == '0);
            started_d = 1'b1;
          end
          dig_d = '0;
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - IdxW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      acc_q     <= '0;
      sum_q     <= '0;
      pend_q    <= 1'b0;
      idx_q     <= '0;
      dig_q     <= '0;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      sum_q     <= sum_d;
      pend_q    <= pend_d;
      idx_q     <= idx_d;
      dig_q     <= dig_d;
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_q   <= add_d;
    rem_q   <= rem_d;
    okind_q <= okind_d;
    oval_q  <= oval_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {ochar_q, oval_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

  a_dig_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StConv |-> dig_q <= 3'd4)
    else $error("digit count out of range");

  a_flush_sum_settled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == CmdFlush) |=> (state_q == StLoad) && !pend_q)
    else $error("flush started with pending sum update");

  a_value_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KindValue) |->
      (m_axis_tlast && m_axis_tdata[ValW+CharW-1:ValW] == '0))
    else $error("value beat malformed");

  a_rem_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv && idx_q == '0) |-> rem_q < RemW'(5))
    else $error("remainder exceeds last digit");

endmodule
